[design/lcdtx_pkg.sv]
// Shared types, constants and lookup functions for the LCD serial frame transmitter.
package lcdtx_pkg;

    localparam int RAM_NIBBLES = 64;

    localparam int FRAME_W   = 13;
    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] MODE_CMD   = 3'b100;
    localparam logic [2:0] MODE_WRITE = 3'b101;
    localparam logic [5:0] DP_BASE_ADDR = 6'h29;
    localparam logic [3:0] DIGIT_LIMIT  = 4'd10;
    localparam logic [3:0] DP_LIMIT     = 4'd9;
    localparam logic [3:0] CMD_BITS     = 4'd12;
    localparam logic [3:0] WRITE_BITS   = 4'd13;

    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_NIBBLE = 2'd1,
        OP_DIGIT  = 2'd2,
        OP_DP     = 2'd3
    } op_t;

    // one queued frame: left-aligned bit word, MSB sent first
    typedef struct packed {
        logic [FRAME_W-1:0] word;
        logic               is_cmd;
        logic               last;
    } frame_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // decimal point: address 0x29 + 2*(pos/3)
    function automatic logic [5:0] dp_addr(input logic [3:0] pos);
        logic [5:0] a;
        a = DP_BASE_ADDR;
        if (pos >= 4'd6) begin
            a = DP_BASE_ADDR + 6'd4;
        end else if (pos >= 4'd3) begin
            a = DP_BASE_ADDR + 6'd2;
        end
        return a;
    endfunction

    // decimal point: data 2 << (pos mod 3)
    function automatic logic [3:0] dp_data(input logic [3:0] pos);
        logic [3:0] d;
        case (pos)
            4'd0, 4'd3, 4'd6: d = 4'b0010;
            4'd1, 4'd4, 4'd7: d = 4'b0100;
            default:          d = 4'b1000;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] rev4(input logic [3:0] v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

[design/lcd_driver_serial_frame_tx.sv]
// Top level of the three-wire segment LCD serial frame transmitter.
// A request passes the front-end registers, the frame queue, the back-end shift
// register and the output register before its first bit shows on m_. Throughput:
// one bit per cycle in a frame while m_tready is high, with a load between frames.
// s_tready rises again once the front end has queued every frame of a request.
// Reset (aresetn low, synchronous) empties the queue and drops any frame in flight.
module lcd_driver_serial_frame_tx
    import lcdtx_pkg::*;
#(
    parameter int NUM_NIBBLES = RAM_NIBBLES
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[7:0], address[13:8], nibble[17:14], digit[21:18],
    // segments[37:22], decimal_pos[41:38], zero fill
    input  logic [47:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_bit[0], zero fill
    output logic [7:0]  m_tdata,
    // frame_end[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    fifo_status_t fifo_status;
    frame_desc_t  push_desc, pop_desc;
    logic         push, pop;

    lcdtx_front #(
        .NUM_NIBBLES (NUM_NIBBLES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .fifo_status (fifo_status),
        .push        (push),
        .push_desc   (push_desc)
    );

    lcdtx_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .status    (fifo_status)
    );

    lcdtx_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_status (fifo_status),
        .pop_desc    (pop_desc),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("request end not on a frame end");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_status.full)
        else $error("frame pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_status.empty)
        else $error("frame popped from empty queue");

    a_accept_only_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !push)
        else $error("request accepted while frames still pending");

endmodule

[design/lcdtx_fifo.sv]
// Short frame queue between the request front end and the serial back end.
module lcdtx_fifo
    import lcdtx_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  frame_desc_t  push_desc,
    input  logic         pop,
    output frame_desc_t  pop_desc,
    output fifo_status_t status
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    frame_desc_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_desc = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[design/lcdtx_front.sv]
// Request front end: decodes display requests into queued frame descriptors.
module lcdtx_front
    import lcdtx_pkg::*;
#(
    parameter int NUM_NIBBLES = RAM_NIBBLES
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  fifo_status_t fifo_status,
    output logic         push,
    output frame_desc_t  push_desc
);

    op_t         op;
    logic [7:0]  command;
    logic [5:0]  address;
    logic [3:0]  nibble;
    logic [3:0]  digit;
    logic [15:0] segments;
    logic [3:0]  decimal_pos;

    logic [15:0] pat_reg, pat_next;
    logic [5:0]  addr_reg, addr_next;
    logic [2:0]  left_reg, left_next;
    logic        is_cmd_reg, is_cmd_next;

    logic        accept, active, addr_ok, next_ok, frame_last, advance;

    assign op          = op_t'(s_tuser);
    assign command     = s_tdata[7:0];
    assign address     = s_tdata[13:8];
    assign nibble      = s_tdata[17:14];
    assign digit       = s_tdata[21:18];
    assign segments    = s_tdata[37:22];
    assign decimal_pos = s_tdata[41:38];

    assign s_tready = (left_reg == 3'd0);
    assign accept   = s_tvalid && s_tready;
    assign active   = (left_reg != 3'd0);
    assign addr_ok  = is_cmd_reg || ({1'b0, addr_reg} < 7'(NUM_NIBBLES));
    assign next_ok  = ({1'b0, addr_reg} + 7'd1) < 7'(NUM_NIBBLES);
    // addresses only rise within a request, so a failed next address ends it
    assign frame_last = (left_reg == 3'd1) || (!is_cmd_reg && !next_ok);
    assign advance  = active && (!addr_ok || !fifo_status.full);
    assign push     = active && addr_ok && !fifo_status.full;

    always_comb begin
        push_desc.is_cmd = is_cmd_reg;
        push_desc.last   = frame_last;
        if (is_cmd_reg) begin
            push_desc.word = {MODE_CMD, pat_reg[15:8], 2'b00};
        end else begin
            push_desc.word = {MODE_WRITE, addr_reg, rev4(pat_reg[15:12])};
        end
    end

    always_comb begin
        pat_next    = pat_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        is_cmd_next = is_cmd_reg;
        if (accept) begin
            is_cmd_next = 1'b0;
            unique case (op)
                OP_CMD: begin
                    is_cmd_next = 1'b1;
                    pat_next    = {command, 8'h00};
                    addr_next   = '0;
                    left_next   = 3'd1;
                end
                OP_NIBBLE: begin
                    pat_next  = {nibble, 12'h000};
                    addr_next = address;
                    left_next = 3'd1;
                end
                OP_DIGIT: begin
                    pat_next  = segments;
                    addr_next = {digit, 2'b00};
                    left_next = (digit < DIGIT_LIMIT) ? 3'd4 : 3'd0;
                end
                OP_DP: begin
                    pat_next  = {dp_data(decimal_pos), 12'h000};
                    addr_next = dp_addr(decimal_pos);
                    left_next = (decimal_pos < DP_LIMIT) ? 3'd1 : 3'd0;
                end
                default: begin
                    left_next = 3'd0;
                end
            endcase
        end else if (advance) begin
            pat_next  = {pat_reg[11:0], 4'h0};
            addr_next = addr_reg + 6'd1;
            left_next = frame_last ? 3'd0 : left_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= 3'd0;
            is_cmd_reg <= 1'b0;
        end else begin
            left_reg   <= left_next;
            is_cmd_reg <= is_cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg  <= pat_next;
        addr_reg <= addr_next;
    end

endmodule

[design/lcdtx_back.sv]
// Serial back end: shifts queued frames out one bit per m_ transfer.
module lcdtx_back
    import lcdtx_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  fifo_status_t fifo_status,
    input  frame_desc_t  pop_desc,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    logic [FRAME_W-1:0] shift_reg, shift_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               flast_reg, flast_next;
    logic               valid_reg, valid_next;
    logic               bit_reg, bit_next;
    logic               fend_reg, fend_next;
    logic               olast_reg, olast_next;
    logic               can_emit;

    assign can_emit = !valid_reg || m_tready;
    assign pop      = (cnt_reg == 4'd0) && !fifo_status.empty;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, bit_reg};
    assign m_tuser  = fend_reg;
    assign m_tlast  = olast_reg;

    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        flast_next = flast_reg;
        valid_next = valid_reg;
        bit_next   = bit_reg;
        fend_next  = fend_reg;
        olast_next = olast_reg;
        if (pop) begin
            shift_next = pop_desc.word;
            cnt_next   = pop_desc.is_cmd ? CMD_BITS : WRITE_BITS;
            flast_next = pop_desc.last;
        end
        if (can_emit) begin
            valid_next = (cnt_reg != 4'd0);
            if (cnt_reg != 4'd0) begin
                bit_next   = shift_reg[FRAME_W-1];
                fend_next  = (cnt_reg == 4'd1);
                olast_next = (cnt_reg == 4'd1) && flast_reg;
                shift_next = {shift_reg[FRAME_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        flast_reg <= flast_next;
        bit_reg   <= bit_next;
        fend_reg  <= fend_next;
        olast_reg <= olast_next;
    end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the three-wire LCD serial frame transmitter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdtx_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_REQUESTS = 420;
    localparam int DRAIN_CYCLES    = 64;

    // request fields from the highest bit down, as packed in s_tdata
    typedef struct packed {
        logic [3:0]  decimal_pos;
        logic [15:0] segments;
        logic [3:0]  digit;
        logic [3:0]  nibble;
        logic [5:0]  address;
        logic [7:0]  command;
    } lcd_req_t;

    typedef struct {
        logic data_bit;
        logic frame_end;
        logic req_end;
    } serial_bit_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_CMD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    serial_bit_t expected_bits[$];
    int          error_count  = 0;
    int          idle_cycles  = 0;
    int          send_burst   = 0;
    int          accept_burst = 0;

    lcd_driver_serial_frame_tx dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // mostly short gaps, a few long ones, and runs with none
    function automatic int gap_len(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- predictor ----------------
    function automatic void push_frame(input logic [12:0] word, input int nbits);
        serial_bit_t b;
        for (int i = nbits - 1; i >= 0; i--) begin
            b.data_bit  = word[i];
            b.frame_end = (i == 0);
            b.req_end   = 1'b0;
            expected_bits.push_back(b);
        end
    endfunction

    function automatic void push_nibble_write(input logic [5:0] addr, input logic [3:0] data);
        logic [3:0] rev_nib;
        if (int'(addr) >= RAM_NIBBLES) return;
        for (int i = 0; i < 4; i++) rev_nib[3 - i] = data[i];
        push_frame({MODE_WRITE, addr, rev_nib}, 13);
    endfunction

    function automatic void predict_serial_bits(input op_t op, input lcd_req_t f);
        int          start_size;
        serial_bit_t tail;
        logic [3:0]  dp_idx;
        logic [3:0]  dp_grp;
        start_size = expected_bits.size();
        case (op)
            OP_CMD: push_frame({1'b0, MODE_CMD, f.command, 1'b0}, 12);
            OP_NIBBLE: push_nibble_write(f.address, f.nibble);
            OP_DIGIT: begin
                if (f.digit < DIGIT_LIMIT) begin
                    for (int k = 0; k < 4; k++)
                        push_nibble_write(6'(f.digit * 4 + k), f.segments[15 - 4*k -: 4]);
                end
            end
            OP_DP: begin
                if (f.decimal_pos < DP_LIMIT) begin
                    dp_grp = f.decimal_pos / 3;
                    dp_idx = f.decimal_pos % 3;
                    push_nibble_write(DP_BASE_ADDR + 6'(2 * dp_grp), 4'(4'd2 << dp_idx));
                end
            end
        endcase
        if (expected_bits.size() > start_size) begin
            tail = expected_bits.pop_back();
            tail.req_end = 1'b1;
            expected_bits.push_back(tail);
        end
    endfunction

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        serial_bit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bits.size() == 0) begin
                report_mismatch($sformatf("unexpected bit %0b frame_end %0b last %0b",
                                          m_tdata[0], m_tuser[0], m_tlast));
            end else begin
                want = expected_bits.pop_front();
                if (m_tdata[0] !== want.data_bit)
                    report_mismatch($sformatf("data_bit %0b, want %0b",
                                              m_tdata[0], want.data_bit));
                if (m_tuser[0] !== want.frame_end)
                    report_mismatch($sformatf("frame_end %0b, want %0b",
                                              m_tuser[0], want.frame_end));
                if (m_tlast !== want.req_end)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.req_end));
                if (m_tdata[7:1] !== 7'd0)
                    report_mismatch($sformatf("tdata fill bits %b", m_tdata[7:1]));
            end
        end
    end

    // ---------------- receiver backpressure ----------------
    initial begin
        int n;
        forever begin
            n = gap_len(accept_burst);
            if (n != 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic lcd_req_t random_fields();
        lcd_req_t f;
        f = lcd_req_t'({$urandom, $urandom});
        return f;
    endfunction

    // valid stays high into the next request when no gap is drawn
    task automatic send_request(input op_t op, input lcd_req_t f);
        int gap;
        gap = gap_len(send_burst);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, f};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predict_serial_bits(op, f);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_bits.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic test_command_frames();
        lcd_req_t f;
        logic [7:0] cmds[3] = '{8'h00, 8'hFF, 8'hA5};
        foreach (cmds[i]) begin
            f = random_fields();
            f.command = cmds[i];
            send_request(OP_CMD, f);
        end
    endtask

    task automatic test_nibble_frames();
        lcd_req_t f;
        logic [5:0] addrs[4] = '{6'd0, 6'd63, 6'h2A, 6'd21};
        logic [3:0] nibs[4]  = '{4'h0, 4'hF, 4'h1, 4'h8};
        foreach (addrs[i]) begin
            f = random_fields();
            f.address = addrs[i];
            f.nibble  = nibs[i];
            send_request(OP_NIBBLE, f);
        end
    endtask

    task automatic test_digit_frames();
        lcd_req_t f;
        logic [3:0]  digits[3] = '{4'd0, 4'd9, 4'd5};
        logic [15:0] pats[3]   = '{16'hFFFF, 16'h1234, 16'h0000};
        foreach (digits[i]) begin
            f = random_fields();
            f.digit    = digits[i];
            f.segments = pats[i];
            send_request(OP_DIGIT, f);
        end
    endtask

    task automatic test_decimal_points();
        lcd_req_t f;
        for (int p = 0; p < 9; p++) begin
            f = random_fields();
            f.decimal_pos = 4'(p);
            send_request(OP_DP, f);
        end
    endtask

    // out-of-range digit and decimal position give no output; a command request follows them
    task automatic test_ignored_requests();
        lcd_req_t f;
        f = random_fields();
        f.digit = 4'd10;
        send_request(OP_DIGIT, f);
        f = random_fields();
        f.digit = 4'd15;
        send_request(OP_DIGIT, f);
        f = random_fields();
        f.decimal_pos = 4'd9;
        send_request(OP_DP, f);
        f = random_fields();
        f.decimal_pos = 4'd15;
        send_request(OP_DP, f);
        f = random_fields();
        f.command = 8'h3C;
        send_request(OP_CMD, f);
    endtask

    task automatic test_drain_pause();
        lcd_req_t f;
        f = random_fields();
        f.digit = 4'(f.digit % 10);
        send_request(OP_DIGIT, f);
        send_request(OP_NIBBLE, random_fields());
        wait_results_drained();
        send_request(OP_CMD, random_fields());
        send_request(OP_DP, random_fields());
    endtask

    task automatic test_random_mix();
        lcd_req_t f;
        op_t      op;
        int       producing;
        int       before_size;
        producing = 0;
        while (producing < RANDOM_REQUESTS) begin
            f  = random_fields();
            op = op_t'($urandom_range(0, 3));
            if (op == OP_DIGIT && $urandom_range(0, 99) < 85)
                f.digit = 4'($urandom_range(0, 9));
            if (op == OP_DP && $urandom_range(0, 99) < 85)
                f.decimal_pos = 4'($urandom_range(0, 8));
            before_size = expected_bits.size();
            send_request(op, f);
            if (expected_bits.size() != before_size) producing++;
            if ($urandom_range(0, 199) == 0) wait_results_drained();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_command_frames();
        test_nibble_frames();
        test_digit_frames();
        test_decimal_points();
        test_ignored_requests();
        test_drain_pause();
        test_random_mix();

        s_tvalid <= 1'b0;
        while (expected_bits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_bits.size() != 0)
            report_mismatch($sformatf("%0d bits never arrived", expected_bits.size()));

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
